// ===== hdl/vgsr_pkg.sv =====
// Package for the glyph stroke rasteriser: widths, codes, reset values and
// small signed helpers.
// No dependencies; used by vgsr_div and vector_glyph_stroke_rasterizer.
package vgsr_pkg;

  // working width of signed pixel coordinates and extents
  localparam int CW = 20;
  // divider data width
  localparam int DIV_W = 32;

  // default frame size
  localparam int FRAME_W_DEF = 256;
  localparam int FRAME_H_DEF = 256;

  // constant divisor for tenths of character size
  localparam int TENTHS = 10;
  // half of TENTHS, for rounding the thickness
  localparam int HALF_TENTH = 5;
  // 2^RECIP_SHIFT / TENTHS rounded up; exact for magnitudes below 2^19
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_TENTH = 419431;

  // configuration register indexes
  localparam logic [2:0] REG_WIN_X    = 3'd0;
  localparam logic [2:0] REG_WIN_Y    = 3'd1;
  localparam logic [2:0] REG_CLIP_L   = 3'd2;
  localparam logic [2:0] REG_CLIP_T   = 3'd3;
  localparam logic [2:0] REG_CLIP_R   = 3'd4;
  localparam logic [2:0] REG_CLIP_B   = 3'd5;

  // clip window reset values
  localparam logic [8:0] CLIP_L_RST = 9'd0;
  localparam logic [8:0] CLIP_T_RST = 9'd0;
  localparam logic [8:0] CLIP_R_RST = 9'd256;
  localparam logic [8:0] CLIP_B_RST = 9'd256;

  // item functions and stroke kinds
  localparam logic      FUNC_READ  = 1'b1;
  localparam logic [1:0] KIND_RECT  = 2'd1;
  localparam logic [1:0] KIND_SHEAR = 2'd2;

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== hdl/vgsr_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// Divisor is taken as positive. Depends on vgsr_pkg.
module vgsr_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [vgsr_pkg::DIV_W-1:0]  dividend,
  input  logic        [vgsr_pkg::DIV_W-1:0]  divisor,
  output logic                               done,
  output logic signed [vgsr_pkg::DIV_W-1:0]  quotient
);

  localparam int DW = vgsr_pkg::DIV_W;
  localparam int NW = $clog2(DW);

  logic          run;
  logic [NW-1:0] cnt;
  logic [DW:0]   rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dvs;
  logic          neg;
  logic [DW:0]   rem_sh;

  // shift in the next dividend bit
  assign rem_sh = {rem[DW-1:0], quo[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        dvs <= divisor;
        neg <= dividend[DW-1];
        quo <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      end else if (run) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == NW'(DW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign fix-up of the magnitude quotient
  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== hdl/vector_glyph_stroke_rasterizer.sv =====
// Glyph stroke rasteriser top level: sequencer, shared multiplier, frame store.
// Depends on vgsr_pkg and vgsr_div.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+--------------------------
//  item in   | func stroke_kind glyph_* origin_* scale   | start high, busy low
//            | color read_x read_y                       |
//  result    | pixel_value is_read                       | done, one cycle, no stall
//  config    | cfg_we cfg_index cfg_data                 | cfg_we, any cycle
//
// A read item passes through ST_RD and ST_RDOUT. A draw item runs five scale passes through one
// multiplier, each a product then a multiply by the reciprocal of ten, then the set-up
// states ST_SETUP1 and ST_SETUP2, then ST_ROW and ST_SPAN per row plus ST_FILL for each pixel
// written, and ST_DONE to finish. Each sheared row also divides by the stroke height in the
// iterative divider. Kinds 0 and 3 go straight to ST_DONE.
// Reset clears the sequencer and configuration; the frame store is not cleared.
// busy stays high until the result strobe; the receiver cannot stall done.
module vector_glyph_stroke_rasterizer #(
  parameter int FRAME_WIDTH  = vgsr_pkg::FRAME_W_DEF,
  parameter int FRAME_HEIGHT = vgsr_pkg::FRAME_H_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [1:0]         stroke_kind,
  input  logic signed [7:0]  glyph_x,
  input  logic signed [7:0]  glyph_y,
  input  logic signed [7:0]  glyph_w,
  input  logic signed [7:0]  glyph_h,
  input  logic [11:0]        origin_x,
  input  logic [11:0]        origin_y,
  input  logic [9:0]         scale,
  input  logic [31:0]        color,
  input  logic [7:0]         read_x,
  input  logic [7:0]         read_y,
  output logic               done,
  output logic [31:0]        pixel_value,
  output logic               is_read,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int CW  = vgsr_pkg::CW;
  localparam int DW  = vgsr_pkg::DIV_W;
  localparam int RS  = vgsr_pkg::RECIP_SHIFT;
  localparam int XBW = $clog2(FRAME_WIDTH);
  localparam int YBW = $clog2(FRAME_HEIGHT);
  localparam int AW  = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam logic signed [CW-1:0] FW_S = CW'(FRAME_WIDTH);
  localparam logic signed [CW-1:0] FH_S = CW'(FRAME_HEIGHT);

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RD     = 4'd1;
  localparam logic [3:0] ST_RDOUT  = 4'd2;
  localparam logic [3:0] ST_MUL    = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_DIVW   = 4'd5;
  localparam logic [3:0] ST_SETUP1 = 4'd6;
  localparam logic [3:0] ST_SETUP2 = 4'd7;
  localparam logic [3:0] ST_ROW    = 4'd8;
  localparam logic [3:0] ST_SPAN   = 4'd9;
  localparam logic [3:0] ST_FILL   = 4'd10;
  localparam logic [3:0] ST_DONE   = 4'd11;
  localparam logic [3:0] ST_REC    = 4'd12;
  localparam logic [3:0] ST_QUO    = 4'd13;

  // multiply/divide pass codes
  localparam logic [2:0] OP_X     = 3'd0;
  localparam logic [2:0] OP_Y     = 3'd1;
  localparam logic [2:0] OP_W     = 3'd2;
  localparam logic [2:0] OP_H     = 3'd3;
  localparam logic [2:0] OP_THICK = 3'd4;
  localparam logic [2:0] OP_ROW   = 3'd5;

  logic [3:0] state;
  logic [2:0] op;

  // configuration registers
  logic [7:0] win_x, win_y;
  logic [8:0] clip_l, clip_t, clip_r, clip_b;

  // latched item
  logic [1:0]        kind;
  logic signed [7:0] gx, gy, gw, gh;
  logic [11:0]       ox, oy;
  logic [9:0]        sc;
  logic [31:0]       col_val;
  logic              rd_ok;

  // stroke geometry
  logic signed [CW-1:0] xs, ys, w, h, s;
  logic signed [CW-1:0] lo, hi, row, row_end, col;

  // shared arithmetic
  logic signed [CW-1:0]   mul_a, mul_b;
  logic signed [2*CW-1:0] prod;
  logic signed [2*CW-1:0] pmag;
  logic                   neg_p;
  logic signed [CW-1:0]   qm, qt;
  logic                   div_start, div_done;
  logic signed [DW-1:0]   div_q;
  logic signed [CW-1:0]   q, x1;
  logic [DW-1:0]          divisor;

  // frame store
  logic [31:0]   mem [DEPTH];
  logic [31:0]   mem_q;
  logic [AW-1:0] addr;
  logic          we;

  logic signed [CW-1:0] cl_s, ct_s, cr_s, cb_s;

  assign cl_s = $signed(CW'(clip_l));
  assign ct_s = $signed(CW'(clip_t));
  assign cr_s = $signed(CW'(clip_r));
  assign cb_s = $signed(CW'(clip_b));

  assign busy = (state != ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_x  <= '0;
      win_y  <= '0;
      clip_l <= vgsr_pkg::CLIP_L_RST;
      clip_t <= vgsr_pkg::CLIP_T_RST;
      clip_r <= vgsr_pkg::CLIP_R_RST;
      clip_b <= vgsr_pkg::CLIP_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vgsr_pkg::REG_WIN_X:  win_x  <= cfg_data[7:0];
        vgsr_pkg::REG_WIN_Y:  win_y  <= cfg_data[7:0];
        vgsr_pkg::REG_CLIP_L: clip_l <= cfg_data;
        vgsr_pkg::REG_CLIP_T: clip_t <= cfg_data;
        vgsr_pkg::REG_CLIP_R: clip_r <= cfg_data;
        vgsr_pkg::REG_CLIP_B: clip_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitude of the scaled product, for the divide by ten
  assign pmag = prod[2*CW-1] ? -prod : prod;

  // multiplier operand select
  always_comb begin
    if (state == ST_REC) begin
      // multiply by the reciprocal of ten
      mul_a = $signed(pmag[CW-1:0]);
      mul_b = CW'(vgsr_pkg::RECIP_TENTH);
    end else begin
      case (op)
        OP_X: begin
          mul_a = $signed(CW'(sc));
          mul_b = CW'(gx);
        end
        OP_Y: begin
          mul_a = $signed(CW'(sc));
          mul_b = CW'(gy);
        end
        OP_W: begin
          mul_a = $signed(CW'(sc));
          mul_b = CW'(gx) + CW'(gw);
        end
        OP_H: begin
          mul_a = $signed(CW'(sc));
          mul_b = CW'(gy) + CW'(gh);
        end
        OP_THICK: begin
          mul_a = $signed(CW'(sc)) + CW'(vgsr_pkg::HALF_TENTH);
          mul_b = CW'(1);
        end
        default: begin
          mul_a = row - ys;
          mul_b = w;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // tenths quotient, truncated toward zero
  assign qm = $signed(CW'(prod[2*CW-1:RS]));
  assign qt = neg_p ? -qm : qm;

  // shear rows divide by the stroke height
  assign divisor   = DW'(h);
  assign div_start = (state == ST_DIV);

  vgsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DW-1:0]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q  = div_q[CW-1:0];
  assign x1 = xs + q;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      op    <= OP_X;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            kind    <= stroke_kind;
            gx      <= glyph_x;
            gy      <= glyph_y;
            gw      <= glyph_w;
            gh      <= glyph_h;
            ox      <= origin_x;
            oy      <= origin_y;
            sc      <= scale;
            col_val <= color;
            row     <= $signed(CW'(read_y));
            col     <= $signed(CW'(read_x));
            rd_ok   <= (CW'(read_x) < CW'(FRAME_WIDTH)) &&
                       (CW'(read_y) < CW'(FRAME_HEIGHT));
            op      <= OP_X;
            if (func == vgsr_pkg::FUNC_READ) begin
              state <= ST_RD;
            end else if (stroke_kind == vgsr_pkg::KIND_RECT ||
                         stroke_kind == vgsr_pkg::KIND_SHEAR) begin
              state <= ST_MUL;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RD: state <= ST_RDOUT;
        ST_RDOUT: begin
          done        <= 1'b1;
          pixel_value <= rd_ok ? mem_q : 32'd0;
          is_read     <= 1'b1;
          state       <= ST_IDLE;
        end
        ST_MUL: state <= (op == OP_ROW) ? ST_DIV : ST_REC;
        ST_REC: begin
          neg_p <= prod[2*CW-1];
          state <= ST_QUO;
        end
        // scaled coordinate ready
        ST_QUO: begin
          case (op)
            OP_X: xs <= qt;
            OP_Y: ys <= qt;
            OP_W: w  <= qt - xs;
            OP_H: h  <= qt - ys;
            OP_THICK: s <= qt;
            default: ;
          endcase
          if (op == OP_THICK) begin
            state <= ST_SETUP1;
          end else begin
            op    <= op + 3'd1;
            state <= ST_MUL;
          end
        end
        ST_DIV: state <= ST_DIVW;
        // sheared row span
        ST_DIVW: begin
          if (div_done) begin
            lo    <= vgsr_pkg::smax(x1, cl_s);
            hi    <= vgsr_pkg::smin(vgsr_pkg::smin(x1 + s, cr_s), FW_S);
            state <= ST_SPAN;
          end
        end
        // origin offsets; window offsets and thickness substitution for rectangles only
        ST_SETUP1: begin
          if (kind == vgsr_pkg::KIND_SHEAR && h <= 0) begin
            state <= ST_DONE;
          end else begin
            if (kind == vgsr_pkg::KIND_RECT) begin
              xs <= xs + $signed(CW'(ox)) + $signed(CW'(win_x));
              ys <= ys + $signed(CW'(oy)) + $signed(CW'(win_y));
              if (gw == 8'sd1) w <= s;
              if (gh == 8'sd1) h <= s;
            end else begin
              xs <= xs + $signed(CW'(ox));
              ys <= ys + $signed(CW'(oy));
            end
            state <= ST_SETUP2;
          end
        end
        // row range and rectangle span, clipped to window and frame
        ST_SETUP2: begin
          row     <= vgsr_pkg::smax(ys, ct_s);
          row_end <= vgsr_pkg::smin(vgsr_pkg::smin(ys + h, cb_s), FH_S);
          lo      <= vgsr_pkg::smax(xs, cl_s);
          hi      <= vgsr_pkg::smin(vgsr_pkg::smin(xs + w, cr_s), FW_S);
          state   <= ST_ROW;
        end
        ST_ROW: begin
          if (row >= row_end) begin
            state <= ST_DONE;
          end else if (kind == vgsr_pkg::KIND_RECT) begin
            state <= ST_SPAN;
          end else begin
            op    <= OP_ROW;
            state <= ST_MUL;
          end
        end
        ST_SPAN: begin
          if (hi > lo) begin
            col   <= lo;
            state <= ST_FILL;
          end else begin
            row   <= row + 1'b1;
            state <= ST_ROW;
          end
        end
        ST_FILL: begin
          if (col + 1'b1 >= hi) begin
            row   <= row + 1'b1;
            state <= ST_ROW;
          end else begin
            col <= col + 1'b1;
          end
        end
        ST_DONE: begin
          done        <= 1'b1;
          pixel_value <= 32'd0;
          is_read     <= 1'b0;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // frame store, row-major
  assign addr = AW'(row[YBW-1:0] * FRAME_WIDTH) + AW'(col[XBW-1:0]);
  assign we   = (state == ST_FILL);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= col_val;
    end
    mem_q <= mem[addr];
  end

`ifndef SYNTH
  // result strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  // a result is only given once the block is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  // pixel writes stay inside the current span
  a_fill_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (col >= lo && col < hi && col >= 0 && row < FH_S))
    else $error("pixel write outside span");
  // draw results carry no pixel
  a_draw_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !is_read) |-> (pixel_value == 32'd0))
    else $error("draw result with pixel data");
`endif

endmodule
